// ===== design/pdq_pkg.sv =====
// Shared types and defaults for the pair deque with dual search.
package pdq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_SEARCH = 2'd2
  } func_e_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e_t;

  typedef struct packed {
    status_e_t status;
    logic      back_valid;
    logic      found_first;
    logic      found_second;
  } res_flags_t;

endpackage

// ===== design/pdq_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
module pdq_ram #(
  parameter int WIDTH = pdq_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = pdq_pkg::DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/pdq_seq.sv =====
// Request sequencer: owns the ring indices and drives the entry RAM per request.
module pdq_seq #(
  parameter int DEPTH      = pdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = pdq_pkg::DATA_WIDTH_DEF,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request side
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_func,
  input  logic [DATA_WIDTH-1:0] in_value_a,
  input  logic [DATA_WIDTH-1:0] in_value_b,
  // result side
  output logic                  res_valid,
  input  logic                  res_ready,
  output pdq_pkg::res_flags_t   res_flags,
  output logic [DATA_WIDTH-1:0] res_front,
  output logic [DATA_WIDTH-1:0] res_back,
  output logic [CW-1:0]         res_occupancy,
  // entry RAM
  output logic                  mem_wr_en,
  output logic [AW-1:0]         mem_wr_addr,
  output logic [DATA_WIDTH-1:0] mem_wr_data,
  output logic                  mem_rd_en,
  output logic [AW-1:0]         mem_rd_addr,
  input  logic [DATA_WIDTH-1:0] mem_rd_data
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_B,
    ST_POP_F,
    ST_POP_B,
    ST_SRCH,
    ST_FINISH
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         front_r, front_nxt;
  logic [AW-1:0]         back_r, back_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [CW-1:0]         left_r, left_nxt;
  logic                  pend_r, pend_nxt;
  logic                  two_r, two_nxt;
  logic [DATA_WIDTH-1:0] key_a_r, key_a_nxt;
  logic [DATA_WIDTH-1:0] key_b_r, key_b_nxt;
  pdq_pkg::status_e_t    status_r, status_nxt;
  logic [DATA_WIDTH-1:0] fo_r, fo_nxt;
  logic [DATA_WIDTH-1:0] bo_r, bo_nxt;
  logic                  bv_r, bv_nxt;
  logic                  f1_r, f1_nxt;
  logic                  f2_r, f2_nxt;

  function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
    return (i == LAST_SLOT) ? '0 : AW'(i + 1'b1);
  endfunction

  function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST_SLOT : AW'(i - 1'b1);
  endfunction

  logic push_full;
  assign push_full = ((CW + 1)'(count_r) + (CW + 1)'(2)) > (CW + 1)'(DEPTH);

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    back_nxt    = back_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    left_nxt    = left_r;
    pend_nxt    = pend_r;
    two_nxt     = two_r;
    key_a_nxt   = key_a_r;
    key_b_nxt   = key_b_r;
    status_nxt  = status_r;
    fo_nxt      = fo_r;
    bo_nxt      = bo_r;
    bv_nxt      = bv_r;
    f1_nxt      = f1_r;
    f2_nxt      = f2_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = back_r;
    mem_wr_data = key_b_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = front_r;
    res_valid   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          status_nxt = pdq_pkg::STATUS_OK;
          fo_nxt     = '0;
          bo_nxt     = '0;
          bv_nxt     = 1'b0;
          f1_nxt     = 1'b0;
          f2_nxt     = 1'b0;
          key_a_nxt  = in_value_a;
          key_b_nxt  = in_value_b;
          unique case (pdq_pkg::func_e_t'(in_func))
            pdq_pkg::FUNC_PUSH: begin
              if (push_full) begin
                status_nxt = pdq_pkg::STATUS_FULL;
                state_nxt  = ST_FINISH;
              end else begin
                // front goes in now, back in the next cycle
                mem_wr_en   = 1'b1;
                mem_wr_addr = slot_prev(front_r);
                mem_wr_data = in_value_a;
                front_nxt   = slot_prev(front_r);
                count_nxt   = CW'(count_r + CW'(2));
                state_nxt   = ST_PUSH_B;
              end
            end
            pdq_pkg::FUNC_POP: begin
              if (count_r == '0) begin
                status_nxt = pdq_pkg::STATUS_EMPTY;
                state_nxt  = ST_FINISH;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = front_r;
                front_nxt   = slot_next(front_r);
                two_nxt     = (count_r != CW'(1));
                count_nxt   = (count_r != CW'(1)) ? CW'(count_r - CW'(2)) : '0;
                state_nxt   = ST_POP_F;
              end
            end
            pdq_pkg::FUNC_SEARCH: begin
              pos_nxt   = front_r;
              left_nxt  = count_r;
              pend_nxt  = 1'b0;
              state_nxt = ST_SRCH;
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end

      ST_PUSH_B: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = back_r;
        mem_wr_data = key_b_r;
        back_nxt    = slot_next(back_r);
        state_nxt   = ST_FINISH;
      end

      ST_POP_F: begin
        fo_nxt = mem_rd_data;
        if (two_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = slot_prev(back_r);
          back_nxt    = slot_prev(back_r);
          state_nxt   = ST_POP_B;
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      ST_POP_B: begin
        bo_nxt    = mem_rd_data;
        bv_nxt    = 1'b1;
        state_nxt = ST_FINISH;
      end

      ST_SRCH: begin
        // compare the word read last cycle while issuing the next read
        if (pend_r) begin
          if (mem_rd_data == key_a_r) f1_nxt = 1'b1;
          if (mem_rd_data == key_b_r) f2_nxt = 1'b1;
        end
        if (left_r != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = pos_r;
          pos_nxt     = slot_next(pos_r);
          left_nxt    = CW'(left_r - 1'b1);
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
      left_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      pend_r  <= pend_nxt;
    end
    pos_r    <= pos_nxt;
    two_r    <= two_nxt;
    key_a_r  <= key_a_nxt;
    key_b_r  <= key_b_nxt;
    status_r <= status_nxt;
    fo_r     <= fo_nxt;
    bo_r     <= bo_nxt;
    bv_r     <= bv_nxt;
    f1_r     <= f1_nxt;
    f2_r     <= f2_nxt;
  end

  assign in_stall               = (state_r != ST_IDLE);
  assign res_flags.status       = status_r;
  assign res_flags.back_valid   = bv_r;
  assign res_flags.found_first  = f1_r;
  assign res_flags.found_second = f2_r;
  assign res_front              = fo_r;
  assign res_back               = bo_r;
  assign res_occupancy          = count_r;

  // ring consistency: back sits count slots after front
  logic [CW:0]   ring_sum;
  logic [CW:0]   ring_wrap;
  assign ring_sum  = (CW + 1)'(front_r) + (CW + 1)'(count_r);
  assign ring_wrap = (ring_sum >= (CW + 1)'(DEPTH)) ? (ring_sum - (CW + 1)'(DEPTH)) : ring_sum;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> AW'(ring_wrap) == back_r)
    else $error("front, back and count disagree");

  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("RAM read and write in the same cycle");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_flags.status == pdq_pkg::STATUS_FULL |-> push_full)
    else $error("full flagged with room left");

endmodule

// ===== design/pair_deque_with_dual_search.sv =====
// Top level of the pair deque with dual search: sequencer, entry RAM, result register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------------
//  in_     | in  | in_valid/in_stall  | func, value_a, value_b
//  out_    | out | out_valid/out_stall| status, front_out, back_out, back_valid,
//          |     |                    | found_first, found_second, occupancy
//
// One request at a time. A push writes the front entry, then the back one; a pop reads the front
// entry, then the back one if more than one is stored. In a search the walk reads one stored entry
// per cycle through the single RAM read port and checks both keys against it.
// A result waits in the output register while the next request is taken.
// rst_n is synchronous; it clears the indices and count, the RAM keeps its contents.
module pair_deque_with_dual_search #(
  parameter int DEPTH      = pdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = pdq_pkg::DATA_WIDTH_DEF,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_func,
  input  logic [DATA_WIDTH-1:0] in_value_a,
  input  logic [DATA_WIDTH-1:0] in_value_b,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [DATA_WIDTH-1:0] out_front_out,
  output logic [DATA_WIDTH-1:0] out_back_out,
  output logic                  out_back_valid,
  output logic                  out_found_first,
  output logic                  out_found_second,
  output logic [CW-1:0]         out_occupancy
);

  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [DATA_WIDTH-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [DATA_WIDTH-1:0] mem_rd_data;

  logic                  res_valid;
  logic                  res_ready;
  pdq_pkg::res_flags_t   res_flags;
  logic [DATA_WIDTH-1:0] res_front;
  logic [DATA_WIDTH-1:0] res_back;
  logic [CW-1:0]         res_occupancy;

  pdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  pdq_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_value_a    (in_value_a),
    .in_value_b    (in_value_b),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_flags     (res_flags),
    .res_front     (res_front),
    .res_back      (res_back),
    .res_occupancy (res_occupancy),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data)
  );

  logic                  out_valid_r, out_valid_nxt;
  pdq_pkg::res_flags_t   flags_r;
  logic [DATA_WIDTH-1:0] front_r;
  logic [DATA_WIDTH-1:0] back_r;
  logic [CW-1:0]         occ_r;
  logic                  load;

  // take a new result when the register is empty or being drained
  assign res_ready = !out_valid_r || !out_stall;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      flags_r <= res_flags;
      front_r <= res_front;
      back_r  <= res_back;
      occ_r   <= res_occupancy;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = flags_r.status;
  assign out_front_out    = front_r;
  assign out_back_out     = back_r;
  assign out_back_valid   = flags_r.back_valid;
  assign out_found_first  = flags_r.found_first;
  assign out_found_second = flags_r.found_second;
  assign out_occupancy    = occ_r;

endmodule
